/* hw/rtl/eltc_pkg.sv */
`timescale 1ns / 1ps

package eltc_pkg;

  // field widths
  localparam int EPOCH_W  = 32;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int OFF_W    = 5;
  localparam int DAY_W    = 17;              // day count up to 49710, plus weekday bias
  localparam int REM_W    = 6;               // remainder bits, divisors up to 60
  localparam int YOFS_W   = 8;               // years past 1970, up to 136
  localparam int MON_W    = 4;
  localparam int WDAY_W   = 3;
  localparam int SUM_W    = 6;               // day remainder plus weekday
  localparam int PROD_W   = 2 * EPOCH_W;

  localparam int OUT_FIELDS_W = HOUR_W + MIN_W + SEC_W + 2;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // calendar constants
  localparam int EPOCH_YEAR    = 1970;
  localparam int NOLEAP_CENT   = 2100;       // only century year in range that is not leap
  localparam int CENT_OFS      = NOLEAP_CENT - EPOCH_YEAR;
  localparam int SEC_PER_MIN   = 60;
  localparam int MIN_PER_HR    = 60;
  localparam int HR_PER_DAY    = 24;
  localparam int DAYS_PER_WEEK = 7;
  localparam int DAYS_YEAR     = 365;
  localparam int DAYS_LEAP     = 366;
  localparam int FEB_LEAP_DAYS = 29;
  localparam int LAST_DOM      = 31;
  localparam int THURSDAY      = 4;          // weekday of day zero, sunday = 0
  // days + (31 - (rem + 1)) + 4 = days + WDAY_BIAS - rem
  localparam int WDAY_BIAS     = LAST_DOM - 1 + THURSDAY;
  // day >= 31 - w31  <=>  rem + w31 >= 30
  localparam int SUMMER_EDGE   = LAST_DOM - 1;

  // reciprocal division: x / d == (x * magic) >> shift over the operand range used
  localparam logic [EPOCH_W-1:0] DIV60_MAGIC = 32'h8888_8889;    // any 32-bit x
  localparam int                 DIV60_SHIFT = 37;
  localparam logic [EPOCH_W-1:0] DIV24_MAGIC = EPOCH_W'(2796203); // x below 2^23
  localparam int                 DIV24_SHIFT = 26;
  localparam logic [EPOCH_W-1:0] DIV7_MAGIC  = EPOCH_W'(74899);   // x below 104857
  localparam int                 DIV7_SHIFT  = 19;

  // zero-based months
  localparam logic [MON_W-1:0] MON_FEB  = MON_W'(1);
  localparam logic [MON_W-1:0] MON_MAR  = MON_W'(2);
  localparam logic [MON_W-1:0] MON_OCT  = MON_W'(9);
  localparam logic [MON_W-1:0] MON_LAST = MON_W'(11);

  localparam logic [4:0] MONTH_DAYS [0:11] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // input kinds on in_tuser
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // configuration register indexes
  localparam logic CFG_STD_OFFSET    = 1'b0;
  localparam logic CFG_SUMMER_OFFSET = 1'b1;

  localparam logic [OFF_W-1:0] STD_OFFSET_RST    = OFF_W'(1);
  localparam logic [OFF_W-1:0] SUMMER_OFFSET_RST = OFF_W'(2);

  typedef struct packed {
    logic              done;
    logic [HOUR_W-1:0] utc_hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              summer;
  } load_res_t;

  function automatic logic [4:0] month_len(input logic [MON_W-1:0] mon, input logic leap);
    logic [4:0] len;
    if (mon > MON_LAST) begin
      len = 5'(LAST_DOM);
    end else if (leap && (mon == MON_FEB)) begin
      len = 5'(FEB_LEAP_DAYS);
    end else begin
      len = MONTH_DAYS[mon];
    end
    return len;
  endfunction

endpackage

/* hw/rtl/eltc_alu.sv */
`timescale 1ns / 1ps

module eltc_alu (
  input  logic [eltc_pkg::DAY_W-1:0]   a,
  input  logic [eltc_pkg::DAY_W-1:0]   b,
  input  logic [eltc_pkg::EPOCH_W-1:0] mul_a,
  input  logic [eltc_pkg::EPOCH_W-1:0] mul_b,
  output logic [eltc_pkg::DAY_W-1:0]   diff,
  output logic                         ge,
  output logic [eltc_pkg::PROD_W-1:0]  prod
);
  import eltc_pkg::*;

  logic [DAY_W:0] full;

  // shared compare-subtract: a - b and a >= b
  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[DAY_W-1:0];
  assign ge   = ~full[DAY_W];

  // shared 32 x 32 multiply, full product
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

endmodule

/* hw/rtl/eltc_seq.sv */
`timescale 1ns / 1ps

module eltc_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [eltc_pkg::EPOCH_W-1:0] epoch,
  output logic                         busy,
  output eltc_pkg::load_res_t          res
);
  import eltc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEC, ST_MIN, ST_HR, ST_YEAR, ST_MONTH, ST_WDAY, ST_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic                ph_r, ph_nxt;       // divide step: 0 quotient, 1 remainder
  logic [EPOCH_W-1:0]  quo_r, quo_nxt;     // dividend of the current divide
  logic [EPOCH_W-1:0]  qt_r, qt_nxt;       // its quotient
  logic [SEC_W-1:0]    sec_r, sec_nxt;
  logic [MIN_W-1:0]    min_r, min_nxt;
  logic [HOUR_W-1:0]   hr_r, hr_nxt;
  logic [DAY_W-1:0]    days_r, days_nxt;
  logic [DAY_W-1:0]    rem_r, rem_nxt;
  logic [YOFS_W-1:0]   yofs_r, yofs_nxt;
  logic [MON_W-1:0]    mon_r, mon_nxt;
  logic [WDAY_W-1:0]   wday_r, wday_nxt;

  logic [DAY_W-1:0]    alu_a, alu_b, alu_diff;
  logic                alu_ge;
  logic [EPOCH_W-1:0]  mul_a, mul_b, qt_mul;
  logic [PROD_W-1:0]   prod;
  logic                leap, div_active;
  logic [REM_W-1:0]    rmd;
  logic [SUM_W-1:0]    edge_sum;
  logic                summer;

  eltc_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .diff  (alu_diff),
    .ge    (alu_ge),
    .prod  (prod)
  );

  // 1970 + yofs is leap when yofs mod 4 is 2, except 2100
  assign leap = (yofs_r[1:0] == 2'd2) && (yofs_r != YOFS_W'(CENT_OFS));

  // divide by a constant: reciprocal multiply for the quotient, then
  // quotient times divisor for the remainder
  always_comb begin
    alu_a  = rem_r;
    alu_b  = '0;
    mul_a  = ph_r ? qt_r : quo_r;
    mul_b  = '0;
    qt_mul = '0;
    unique case (state_r)
      ST_SEC: begin
        mul_b  = ph_r ? EPOCH_W'(SEC_PER_MIN) : DIV60_MAGIC;
        qt_mul = EPOCH_W'(prod >> DIV60_SHIFT);
      end
      ST_MIN: begin
        mul_b  = ph_r ? EPOCH_W'(MIN_PER_HR) : DIV60_MAGIC;
        qt_mul = EPOCH_W'(prod >> DIV60_SHIFT);
      end
      ST_HR: begin
        mul_b  = ph_r ? EPOCH_W'(HR_PER_DAY) : DIV24_MAGIC;
        qt_mul = EPOCH_W'(prod >> DIV24_SHIFT);
      end
      ST_WDAY: begin
        mul_b  = ph_r ? EPOCH_W'(DAYS_PER_WEEK) : DIV7_MAGIC;
        qt_mul = EPOCH_W'(prod >> DIV7_SHIFT);
      end
      ST_YEAR:  alu_b = leap ? DAY_W'(DAYS_LEAP) : DAY_W'(DAYS_YEAR);
      ST_MONTH: alu_b = DAY_W'(month_len(mon_r, leap));
      default:  alu_b = '0;
    endcase
  end

  assign div_active = (state_r == ST_SEC) || (state_r == ST_MIN) ||
                      (state_r == ST_HR) || (state_r == ST_WDAY);
  // remainder is below 64, so the low bits of the difference suffice
  assign rmd        = quo_r[REM_W-1:0] - prod[REM_W-1:0];

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    quo_nxt   = quo_r;
    qt_nxt    = qt_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hr_nxt    = hr_r;
    days_nxt  = days_r;
    rem_nxt   = rem_r;
    yofs_nxt  = yofs_r;
    mon_nxt   = mon_r;
    wday_nxt  = wday_r;

    if (div_active) begin
      if (!ph_r) begin
        qt_nxt = qt_mul;
        ph_nxt = 1'b1;
      end else begin
        quo_nxt = qt_r;
        ph_nxt  = 1'b0;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          quo_nxt   = epoch;
          ph_nxt    = 1'b0;
          state_nxt = ST_SEC;
        end
      end
      ST_SEC: begin
        if (ph_r) begin
          sec_nxt   = rmd;
          state_nxt = ST_MIN;
        end
      end
      ST_MIN: begin
        if (ph_r) begin
          min_nxt   = rmd;
          state_nxt = ST_HR;
        end
      end
      ST_HR: begin
        if (ph_r) begin
          hr_nxt    = rmd[HOUR_W-1:0];
          days_nxt  = qt_r[DAY_W-1:0];
          rem_nxt   = qt_r[DAY_W-1:0];
          yofs_nxt  = '0;
          state_nxt = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (alu_ge) begin
          rem_nxt  = alu_diff;
          yofs_nxt = yofs_r + YOFS_W'(1);
        end else begin
          mon_nxt   = '0;
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (alu_ge && (mon_r != MON_LAST)) begin
          rem_nxt = alu_diff;
          mon_nxt = mon_r + MON_W'(1);
        end else begin
          // day index of the 31st of this month plus the weekday bias, weekday found mod 7
          quo_nxt   = EPOCH_W'(days_r + DAY_W'(WDAY_BIAS) - rem_r);
          ph_nxt    = 1'b0;
          state_nxt = ST_WDAY;
        end
      end
      ST_WDAY: begin
        if (ph_r) begin
          wday_nxt  = rmd[WDAY_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
    quo_r  <= quo_nxt;
    qt_r   <= qt_nxt;
    sec_r  <= sec_nxt;
    min_r  <= min_nxt;
    hr_r   <= hr_nxt;
    days_r <= days_nxt;
    rem_r  <= rem_nxt;
    yofs_r <= yofs_nxt;
    mon_r  <= mon_nxt;
    wday_r <= wday_nxt;
  end

  // summer from last sunday of march through the day before last sunday of october
  assign edge_sum = SUM_W'(rem_r[4:0]) + SUM_W'(wday_r);

  always_comb begin
    priority if ((mon_r < MON_MAR) || (mon_r > MON_OCT)) begin
      summer = 1'b0;
    end else if (mon_r == MON_MAR) begin
      summer = (edge_sum >= SUM_W'(SUMMER_EDGE));
    end else if (mon_r == MON_OCT) begin
      summer = (edge_sum < SUM_W'(SUMMER_EDGE));
    end else begin
      summer = 1'b1;
    end
  end

  assign busy         = (state_r != ST_IDLE);
  assign res.done     = (state_r == ST_DONE);
  assign res.utc_hour = hr_r;
  assign res.minute   = min_r;
  assign res.second   = sec_r;
  assign res.summer   = summer;

endmodule

/* hw/rtl/eltc_clock.sv */
`timescale 1ns / 1ps

module eltc_clock (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick_acc,
  input  eltc_pkg::load_res_t         load_res,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [eltc_pkg::OFF_W-1:0]  cfg_wdata,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [eltc_pkg::HOUR_W-1:0] hour,
  output logic [eltc_pkg::MIN_W-1:0]  minute,
  output logic [eltc_pkg::SEC_W-1:0]  second,
  output logic                        summer,
  output logic                        valid
);
  import eltc_pkg::*;

  localparam int H_W = HOUR_W + 2;

  logic [OFF_W-1:0]  std_off_r, sum_off_r;
  logic [HOUR_W-1:0] hour_r, hour_nxt;
  logic [MIN_W-1:0]  min_r, min_nxt;
  logic [SEC_W-1:0]  sec_r, sec_nxt;
  logic              summer_r, summer_nxt;
  logic              valid_r, valid_nxt;
  logic              ovld_r, ovld_nxt;
  logic [OFF_W-1:0]  off_sel;
  logic signed [H_W-1:0] h_sum;
  logic [HOUR_W-1:0] h_local;

  // local hour: utc hour plus offset, one add or subtract of 24
  assign off_sel = load_res.summer ? sum_off_r : std_off_r;
  assign h_sum   = $signed({2'b00, load_res.utc_hour}) + H_W'($signed(off_sel));

  always_comb begin
    priority if (h_sum >= H_W'(HR_PER_DAY)) begin
      h_local = HOUR_W'(h_sum - H_W'(HR_PER_DAY));
    end else if (h_sum < 0) begin
      h_local = HOUR_W'(h_sum + H_W'(HR_PER_DAY));
    end else begin
      h_local = HOUR_W'(h_sum);
    end
  end

  always_comb begin
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    summer_nxt = summer_r;
    valid_nxt  = valid_r;
    ovld_nxt   = ovld_r && !out_tready;

    if (load_res.done) begin
      hour_nxt   = h_local;
      min_nxt    = load_res.minute;
      sec_nxt    = load_res.second;
      summer_nxt = load_res.summer;
      valid_nxt  = 1'b1;
      ovld_nxt   = 1'b1;
    end else if (tick_acc) begin
      ovld_nxt = 1'b1;
      if (valid_r) begin
        if (sec_r == SEC_W'(SEC_PER_MIN - 1)) begin
          sec_nxt = '0;
          if (min_r == MIN_W'(MIN_PER_HR - 1)) begin
            min_nxt  = '0;
            hour_nxt = (hour_r == HOUR_W'(HR_PER_DAY - 1)) ? '0 : hour_r + HOUR_W'(1);
          end else begin
            min_nxt = min_r + MIN_W'(1);
          end
        end else begin
          sec_nxt = sec_r + SEC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      std_off_r <= STD_OFFSET_RST;
      sum_off_r <= SUMMER_OFFSET_RST;
      hour_r    <= '0;
      min_r     <= '0;
      sec_r     <= '0;
      summer_r  <= 1'b0;
      valid_r   <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STD_OFFSET:    std_off_r <= cfg_wdata;
          CFG_SUMMER_OFFSET: sum_off_r <= cfg_wdata;
          default:           std_off_r <= std_off_r;
        endcase
      end
      hour_r   <= hour_nxt;
      min_r    <= min_nxt;
      sec_r    <= sec_nxt;
      summer_r <= summer_nxt;
      valid_r  <= valid_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign hour       = hour_r;
  assign minute     = min_r;
  assign second     = sec_r;
  assign summer     = summer_r;
  assign valid      = valid_r;

endmodule

/* hw/rtl/epoch_to_local_time_clock.sv */
`timescale 1ns / 1ps

// channel  dir  signals                         contents
// in_      in   in_tvalid/in_tready/in_tdata    epoch_seconds in tdata, mode in tuser
// out_     out  out_tvalid/out_tready/out_tdata hour, minute, second, summer, valid
// cfg_     in   cfg_we/cfg_index/cfg_wdata      0: standard offset, 1: summer offset
//
// a tick's result is registered at the accepting edge
// a load divides by 60, 60 and 24 (each a reciprocal multiply, then the remainder), walks
// the years since 1970 and then the months, finds the weekday mod 7 the same way, and
// commits; its length is set by the year walk on the shared unit
// in_tready is low while a load runs and while a result waits with out_tready low
// synchronous active-low reset: clock invalid at 00:00:00, offsets +1 and +2 hours

module epoch_to_local_time_clock (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input transfer
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [eltc_pkg::EPOCH_W-1:0]         in_tdata,   // [31:0] epoch_seconds
  input  logic                                 in_tuser,   // [0] mode: 0 tick, 1 load
  // result transfer
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [4:0] hour, [10:5] minute, [16:11] second, [17] summer_active, [18] time_valid
  output logic [eltc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // configuration
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [eltc_pkg::OFF_W-1:0]           cfg_wdata
);
  import eltc_pkg::*;

  logic              busy;
  logic              in_xfer, load_go, tick_acc;
  load_res_t         load_res;
  logic [HOUR_W-1:0] hour;
  logic [MIN_W-1:0]  minute;
  logic [SEC_W-1:0]  second;
  logic              summer, valid;

  // one item in flight; the result slot frees at the same edge a new item is taken
  assign in_tready = !busy && (!out_tvalid || out_tready);
  assign in_xfer   = in_tvalid && in_tready;
  assign load_go   = in_xfer && (in_tuser == MODE_LOAD);
  assign tick_acc  = in_xfer && (in_tuser == MODE_TICK);

  // load sequencer: divider, year and month walk, weekday, summer decision
  eltc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (load_go),
    .epoch (in_tdata),
    .busy  (busy),
    .res   (load_res)
  );

  // time-of-day registers, tick counter, offsets and result valid
  eltc_clock u_clock (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_acc   (tick_acc),
    .load_res   (load_res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .hour       (hour),
    .minute     (minute),
    .second     (second),
    .summer     (summer),
    .valid      (valid)
  );

  // result fields come straight from the state registers, which only change on a tick transfer or a finished load
  assign out_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                      valid, summer, second, minute, hour};

endmodule

/* hw/rtl/eltc_chk.sv */
`timescale 1ns / 1ps

module eltc_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [eltc_pkg::EPOCH_W-1:0]     in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [eltc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             cfg_we,
  input logic                             cfg_index,
  input logic [eltc_pkg::OFF_W-1:0]       cfg_wdata
);
  import eltc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a tick answers in the next cycle
  a_tick_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_TICK) |=> out_tvalid)
    else $error("tick result missing");

  // a load occupies the block: no result and no new item right after it
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_LOAD) |=> !out_tvalid && !in_tready)
    else $error("load not sequenced");

  // a waiting result blocks the input
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken over pending result");

  // time fields stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] < 5'd24) && (out_tdata[10:5] < 6'd60) &&
                   (out_tdata[16:11] < 6'd60))
    else $error("time field out of range");

endmodule

bind epoch_to_local_time_clock eltc_chk u_eltc_chk (.*);
